// ===== rtl/bb3_pkg.sv =====
// shared constants, types and the reciprocal table for the 3x3 box blur
package bb3_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int CHANNEL_BITS = 8;
   localparam int NUM_CHANNELS = 3;
   localparam int PIX_BITS     = NUM_CHANNELS * CHANNEL_BITS;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS   = COL_BITS + 1;
   localparam int CFG_BITS     = 12;
   localparam int ROW_BITS     = CFG_BITS;
   localparam int WIN_TAPS     = 9;

   // sum of up to nine channel values, doubled and rounded
   localparam int SUM_BITS     = $clog2(WIN_TAPS * ((1 << CHANNEL_BITS) - 1) + 1);
   localparam int NUM_BITS     = SUM_BITS + 1;
   localparam int COUNT_BITS   = 4;
   localparam int RECIP_SHIFT  = 18;
   localparam int RECIP_BITS   = RECIP_SHIFT;
   localparam int PROD_BITS    = NUM_BITS + RECIP_BITS;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

   localparam logic [CFG_BITS-1:0] RESET_IMAGE_WIDTH  = 12'd640;
   localparam logic [CFG_BITS-1:0] RESET_IMAGE_HEIGHT = 12'd480;

   typedef logic [PIX_BITS-1:0] pix_type;
   typedef logic [WIN_TAPS-1:0][PIX_BITS-1:0] window_type;

   // which window rows and columns count for one result, plus its flags
   typedef struct packed {
      logic [2:0] row_mask;
      logic [2:0] col_mask;
      logic       eof;
      logic       last;
   } sel_type;

   // ceil(2^RECIP_SHIFT / (2*n)): exact floor division for numerators below 2^13
   function automatic logic [RECIP_BITS-1:0] recip(input logic [COUNT_BITS-1:0] n);
      logic [RECIP_BITS-1:0] r;
      unique case (n)
         4'd2:    r = 18'd65536;
         4'd3:    r = 18'd43691;
         4'd4:    r = 18'd32768;
         4'd6:    r = 18'd21846;
         4'd9:    r = 18'd14564;
         default: r = 18'd131072;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/bb3_ram.sv =====
// generic single write port, single read port ram with registered read
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bb3_mean.sv =====
// masked window sums, then rounded mean by reciprocal multiply
module bb3_mean (
   input  logic                                     clock,
   input  logic                                     sum_en,
   input  bb3_pkg::window_type                      window,
   input  bb3_pkg::sel_type                         sel,
   output logic [bb3_pkg::NUM_CHANNELS-1:0][bb3_pkg::CHANNEL_BITS-1:0] mean
);

   logic [bb3_pkg::NUM_CHANNELS-1:0][bb3_pkg::SUM_BITS-1:0] sum_in;
   logic [bb3_pkg::NUM_CHANNELS-1:0][bb3_pkg::SUM_BITS-1:0] sum_ff;
   logic [bb3_pkg::COUNT_BITS-1:0] count_in;
   logic [bb3_pkg::COUNT_BITS-1:0] count_ff;
   logic [1:0] rows_valid;
   logic [1:0] cols_valid;
   logic [bb3_pkg::RECIP_BITS-1:0] recip_val;

   always_comb begin
      for (int ch = 0; ch < bb3_pkg::NUM_CHANNELS; ch++) begin
         sum_in[ch] = '0;
         for (int ri = 0; ri < 3; ri++) begin
            for (int ci = 0; ci < 3; ci++) begin
               if (sel.row_mask[ri] && sel.col_mask[ci]) begin
                  sum_in[ch] = sum_in[ch] + bb3_pkg::SUM_BITS'(
                     window[ri*3+ci][ch*bb3_pkg::CHANNEL_BITS +: bb3_pkg::CHANNEL_BITS]);
               end
            end
         end
      end
      rows_valid = 2'($countones(sel.row_mask));
      cols_valid = 2'($countones(sel.col_mask));
      count_in   = bb3_pkg::COUNT_BITS'(rows_valid) * bb3_pkg::COUNT_BITS'(cols_valid);
   end

   always_ff @(posedge clock) begin
      if (sum_en) begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   assign recip_val = bb3_pkg::recip(count_ff);

   // (2*sum + n) / (2*n) with half-up rounding
   always_comb begin
      for (int ch = 0; ch < bb3_pkg::NUM_CHANNELS; ch++) begin
         logic [bb3_pkg::NUM_BITS-1:0]  numer;
         logic [bb3_pkg::PROD_BITS-1:0] prod;
         numer    = {sum_ff[ch], 1'b0} + bb3_pkg::NUM_BITS'(count_ff);
         prod     = bb3_pkg::PROD_BITS'(numer) * bb3_pkg::PROD_BITS'(recip_val);
         mean[ch] = prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHANNEL_BITS];
      end
   end

endmodule

// ===== rtl/box_blur_3x3_edge_aware_core.sv =====
// top level of the 3x3 edge-aware box blur
//
//   channel | direction | handshake            | contents
//   req_    | in        | req_valid/req_ready  | func, in_red, in_green, in_blue
//   rsp_    | out       | rsp_valid/rsp_ready  | blur_red/green/blue, end_of_frame, last_in_run
//   csr_    | in        | csr_wr_en            | csr_index, csr_wdata
//
// one item at a time: each item takes a read step, then a sum and a multiply step per
// result, set by the single read of both line stores and the shared sum/multiply unit
// reset clears the control state and loads width 640 and height 480
// a result held on rsp_ stalls only the next multiply step; a new item can be
// taken while the final result of the previous one waits for its transfer
module box_blur_3x3_edge_aware_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [bb3_pkg::CHANNEL_BITS-1:0]   req_in_red,
   input  logic [bb3_pkg::CHANNEL_BITS-1:0]   req_in_green,
   input  logic [bb3_pkg::CHANNEL_BITS-1:0]   req_in_blue,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [bb3_pkg::CHANNEL_BITS-1:0]   rsp_blur_red,
   output logic [bb3_pkg::CHANNEL_BITS-1:0]   rsp_blur_green,
   output logic [bb3_pkg::CHANNEL_BITS-1:0]   rsp_blur_blue,
   output logic                               rsp_end_of_frame,
   output logic                               rsp_last_in_run,
   input  logic                               csr_wr_en,
   input  logic [bb3_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bb3_pkg::CFG_BITS-1:0]       csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SUM  = 2'd2;
   localparam logic [1:0] ST_MUL  = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [bb3_pkg::CFG_BITS-1:0] width_ff, width_in;
   logic [bb3_pkg::CFG_BITS-1:0] height_ff, height_in;
   logic [bb3_pkg::COL_BITS-1:0] col_ff, col_in;
   logic [bb3_pkg::ROW_BITS-1:0] row_ff, row_in;

   logic [bb3_pkg::COL_BITS-1:0] addr_ff, addr_in;
   bb3_pkg::pix_type             px_ff, px_in;
   bb3_pkg::window_type          win_ff, win_in;
   bb3_pkg::sel_type             sel_ff, sel_in;
   bb3_pkg::sel_type             sel2_ff, sel2_in;
   logic                         pending_ff, pending_in;
   logic                         any_ff, any_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bb3_pkg::NUM_CHANNELS-1:0][bb3_pkg::CHANNEL_BITS-1:0] rsp_mean_ff, rsp_mean_in;
   logic                         rsp_eof_ff, rsp_eof_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [bb3_pkg::WIDTH_BITS-1:0] w_eff;
   logic [bb3_pkg::ROW_BITS-1:0]   h_eff;
   logic [bb3_pkg::COL_BITS-1:0]   c_cur;
   logic [bb3_pkg::ROW_BITS-1:0]   r_cur;
   logic                           c_last;
   logic                           emit_first, emit_second;
   bb3_pkg::sel_type               first_sel, second_sel;

   logic                         accept;
   logic                         out_free;
   logic                         store_wr;
   bb3_pkg::pix_type             upper_rd, lower_rd;
   logic [bb3_pkg::NUM_CHANNELS-1:0][bb3_pkg::CHANNEL_BITS-1:0] mean;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign store_wr  = (state_ff == ST_READ);

   // effective frame size and wrapped position of the incoming item
   always_comb begin
      if (width_ff == '0) begin
         w_eff = bb3_pkg::WIDTH_BITS'(1);
      end else if (32'(width_ff) > bb3_pkg::MAX_WIDTH) begin
         w_eff = bb3_pkg::WIDTH_BITS'(bb3_pkg::MAX_WIDTH);
      end else begin
         w_eff = bb3_pkg::WIDTH_BITS'(width_ff);
      end
      h_eff  = (height_ff == '0) ? bb3_pkg::ROW_BITS'(1) : height_ff;
      c_cur  = (bb3_pkg::WIDTH_BITS'(col_ff) >= w_eff) ? '0 : col_ff;
      r_cur  = (row_ff > h_eff) ? '0 : row_ff;
      c_last = (bb3_pkg::WIDTH_BITS'(c_cur) + 1'b1) == w_eff;

      emit_first  = (r_cur != '0) && (c_cur != '0);
      emit_second = (r_cur != '0) && c_last;

      // window rows: top only below row 1, bottom only inside the image
      first_sel.row_mask  = {r_cur < h_eff, 1'b1, r_cur >= bb3_pkg::ROW_BITS'(2)};
      first_sel.col_mask  = {1'b1, 1'b1, c_cur >= bb3_pkg::COL_BITS'(2)};
      first_sel.eof       = 1'b0;
      first_sel.last      = !c_last;
      // last pixel of the row sits in the newest column, its left neighbor next to it
      second_sel.row_mask = first_sel.row_mask;
      second_sel.col_mask = {1'b1, c_cur != '0, 1'b0};
      second_sel.eof      = (r_cur == h_eff);
      second_sel.last     = 1'b1;
   end

   // req_func is not needed: the row position alone marks the flush row
   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      addr_in      = addr_ff;
      px_in        = px_ff;
      win_in       = win_ff;
      sel_in       = sel_ff;
      sel2_in      = sel2_ff;
      pending_in   = pending_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_eof_in   = rsp_eof_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            bb3_pkg::REG_IMAGE_WIDTH:  width_in  = csr_wdata;
            bb3_pkg::REG_IMAGE_HEIGHT: height_in = csr_wdata;
            default:                   width_in  = width_ff;
         endcase
         col_in = '0;
         row_in = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in    = c_cur;
               px_in      = {req_in_red, req_in_green, req_in_blue};
               sel_in     = emit_first ? first_sel : second_sel;
               sel2_in    = second_sel;
               pending_in = emit_first && emit_second;
               any_in     = emit_first || emit_second;
               if (c_last) begin
                  col_in = '0;
                  row_in = (r_cur >= h_eff) ? '0 : r_cur + 1'b1;
               end else begin
                  col_in = c_cur + 1'b1;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            // line store data is valid now: shift the new column into the window
            for (int ri = 0; ri < 3; ri++) begin
               win_in[ri*3]   = win_ff[ri*3+1];
               win_in[ri*3+1] = win_ff[ri*3+2];
            end
            win_in[2] = upper_rd;
            win_in[5] = lower_rd;
            win_in[8] = px_ff;
            state_in  = any_ff ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean;
               rsp_eof_in   = sel_ff.eof;
               rsp_last_in  = sel_ff.last;
               if (pending_ff) begin
                  sel_in     = sel2_ff;
                  pending_in = 1'b0;
                  state_in   = ST_SUM;
               end else begin
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= bb3_pkg::RESET_IMAGE_WIDTH;
         height_ff    <= bb3_pkg::RESET_IMAGE_HEIGHT;
         col_ff       <= '0;
         row_ff       <= '0;
         win_ff       <= '0;
         pending_ff   <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         win_ff       <= win_in;
         pending_ff   <= pending_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      px_ff       <= px_in;
      sel_ff      <= sel_in;
      sel2_ff     <= sel2_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_eof_ff  <= rsp_eof_in;
      rsp_last_ff <= rsp_last_in;
   end

   // read at transfer, write back in the read state; the next read waits for idle
   bb3_ram #(
      .WIDTH (bb3_pkg::PIX_BITS),
      .DEPTH (bb3_pkg::MAX_WIDTH)
   ) u_upper_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (addr_ff),
      .wr_data (lower_rd),
      .rd_en   (accept),
      .rd_addr (c_cur),
      .rd_data (upper_rd)
   );

   bb3_ram #(
      .WIDTH (bb3_pkg::PIX_BITS),
      .DEPTH (bb3_pkg::MAX_WIDTH)
   ) u_lower_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (addr_ff),
      .wr_data (px_ff),
      .rd_en   (accept),
      .rd_addr (c_cur),
      .rd_data (lower_rd)
   );

   bb3_mean u_mean (
      .clock  (clock),
      .sum_en (state_ff == ST_SUM),
      .window (win_ff),
      .sel    (sel_ff),
      .mean   (mean)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_blur_red     = rsp_mean_ff[2];
   assign rsp_blur_green   = rsp_mean_ff[1];
   assign rsp_blur_blue    = rsp_mean_ff[0];
   assign rsp_end_of_frame = rsp_eof_ff;
   assign rsp_last_in_run  = rsp_last_ff;

endmodule
